### hdl/voxel_visible_face_finder_top_macros.svh
// Assertion macros used by the voxel face finder checker.
`ifndef VOXEL_VISIBLE_FACE_FINDER_TOP_MACROS_SVH
`define VOXEL_VISIBLE_FACE_FINDER_TOP_MACROS_SVH

// Check that is switched off while reset is held.
`define VVFF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also samples the reset cycles themselves.
`define VVFF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/vvff_pkg.sv
// Shared constants, types and codes of the voxel visible-face finder.
package vvff_pkg;

  localparam int CHUNK_SIZE   = 32;
  localparam int CHUNK_HEIGHT = 64;

  localparam int X_W       = 5;
  localparam int Y_W       = 5;
  localparam int Z_W       = 6;
  localparam int FACE_W    = 3;
  localparam int NUM_FACES = 6;

  localparam int VOXELS = CHUNK_SIZE * CHUNK_SIZE * CHUNK_HEIGHT;
  localparam int ADDR_W = $clog2(VOXELS);

  // Probe 0 reads the voxel itself, probes 1..6 read the neighbours.
  localparam int NUM_PROBES = NUM_FACES + 1;
  localparam int STEP_W     = $clog2(NUM_PROBES + 1);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef logic [FACE_W-1:0] face_t;
  typedef logic [STEP_W-1:0] step_t;

  localparam face_t FACE_RIGHT  = face_t'(0);
  localparam face_t FACE_LEFT   = face_t'(1);
  localparam face_t FACE_FRONT  = face_t'(2);
  localparam face_t FACE_BACK   = face_t'(3);
  localparam face_t FACE_TOP    = face_t'(4);
  localparam face_t FACE_BOTTOM = face_t'(5);

  localparam step_t STEP_CENTRE      = step_t'(0);
  localparam step_t STEP_CENTRE_DATA = step_t'(1);
  localparam step_t STEP_FACE_DATA   = step_t'(2);
  localparam step_t STEP_LAST        = step_t'(NUM_PROBES);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic  clear;
    logic  accept;
    logic  probe;
    step_t step;
    logic  emit;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic is_query;
    logic faces_left;
  } dp_status_t;

endpackage

### hdl/vvff_ifs.sv
// Valid/ready channel interfaces for input items and face results.
interface vvff_in_if;
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic [vvff_pkg::X_W-1:0]   pos_x;
  logic [vvff_pkg::Y_W-1:0]   pos_y;
  logic [vvff_pkg::Z_W-1:0]   pos_z;
  logic                       solid;

  modport source (output valid, command, pos_x, pos_y, pos_z, solid, input ready);
  modport sink   (input valid, command, pos_x, pos_y, pos_z, solid, output ready);
endinterface

interface vvff_out_if;
  logic                       valid;
  logic                       ready;
  vvff_pkg::face_t            face;
  logic [vvff_pkg::X_W-1:0]   face_x;
  logic [vvff_pkg::Y_W-1:0]   face_y;
  logic [vvff_pkg::Z_W-1:0]   face_z;
  logic                       last;

  modport source (output valid, face, face_x, face_y, face_z, last, input ready);
  modport sink   (input valid, face, face_x, face_y, face_z, last, output ready);
endinterface

### hdl/vvff_ctrl.sv
// Controller state machine: memory clear, item accept, probe sequence, face output.
module vvff_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  vvff_pkg::dp_status_t status,
  output vvff_pkg::dp_cmd_t    cmd
);
  import vvff_pkg::*;

  ctrl_state_t state_r, state_nxt;
  step_t       step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      step_r  <= STEP_CENTRE;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = STEP_CENTRE;
    case (state_r)
      ST_CLEAR: begin
        if (status.clear_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid && status.is_query) state_nxt = ST_PROBE;
      end
      ST_PROBE: begin
        if (step_r == STEP_LAST) begin
          state_nxt = ST_EMIT;
        end else begin
          step_nxt = step_r + step_t'(1);
        end
      end
      ST_EMIT: begin
        if (!status.faces_left) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.clear  = 1'b0;
    cmd.accept = 1'b0;
    cmd.probe  = 1'b0;
    cmd.step   = step_r;
    cmd.emit   = 1'b0;
    case (state_r)
      ST_CLEAR: cmd.clear = 1'b1;
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_PROBE: cmd.probe = 1'b1;
      ST_EMIT:  cmd.emit  = 1'b1;
      default: ;
    endcase
  end

endmodule

### hdl/vvff_datapath.sv
// Datapath: occupancy memory, neighbour probes, visible-face mask and output register.
module vvff_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  vvff_pkg::dp_cmd_t         cmd,
  output vvff_pkg::dp_status_t      status,
  input  logic                      in_command,
  input  logic [vvff_pkg::X_W-1:0]  in_pos_x,
  input  logic [vvff_pkg::Y_W-1:0]  in_pos_y,
  input  logic [vvff_pkg::Z_W-1:0]  in_pos_z,
  input  logic                      in_solid,
  input  logic                      out_ready,
  output logic                      out_valid,
  output vvff_pkg::face_t           out_face,
  output logic [vvff_pkg::X_W-1:0]  out_face_x,
  output logic [vvff_pkg::Y_W-1:0]  out_face_y,
  output logic [vvff_pkg::Z_W-1:0]  out_face_z,
  output logic                      out_last
);
  import vvff_pkg::*;

  function automatic logic in_chunk(input int x, input int y, input int z);
    return x inside {[0:CHUNK_SIZE-1]} && y inside {[0:CHUNK_SIZE-1]} &&
           z inside {[0:CHUNK_HEIGHT-1]};
  endfunction

  function automatic logic [ADDR_W-1:0] voxel_addr(input int x, input int y, input int z);
    int a;
    a = (x * CHUNK_SIZE + y) * CHUNK_HEIGHT + z;
    return a[ADDR_W-1:0];
  endfunction

  logic                  mem [VOXELS];
  logic                  rd_r;
  logic                  pin_r;
  logic [ADDR_W-1:0]     clr_cnt_r;
  logic [X_W-1:0]        x_r;
  logic [Y_W-1:0]        y_r;
  logic [Z_W-1:0]        z_r;
  logic                  centre_r;
  logic [NUM_FACES-1:0]  mask_r;
  logic                  out_valid_r;
  face_t                 face_r;
  logic [X_W-1:0]        face_x_r;
  logic [Y_W-1:0]        face_y_r;
  logic [Z_W-1:0]        face_z_r;
  logic                  last_r;

  int                    px, py, pz;
  logic                  pin;
  face_t                 probe_face;
  face_t                 cap_idx;
  logic                  mem_we;
  logic                  mem_wd;
  logic [ADDR_W-1:0]     mem_addr;
  face_t                 sel_face;
  logic                  found;
  logic [NUM_FACES-1:0]  rest;
  logic                  load;

  // Neighbour coordinates of the current probe step.
  always_comb begin
    px = int'(x_r);
    py = int'(y_r);
    pz = int'(z_r);
    probe_face = face_t'(cmd.step - STEP_CENTRE_DATA);
    if (cmd.step != STEP_CENTRE) begin
      case (probe_face)
        FACE_RIGHT:  px = px + 1;
        FACE_LEFT:   px = px - 1;
        FACE_FRONT:  py = py + 1;
        FACE_BACK:   py = py - 1;
        FACE_TOP:    pz = pz + 1;
        FACE_BOTTOM: pz = pz - 1;
        default:     px = -1;
      endcase
    end
    pin = in_chunk(px, py, pz);
  end

  always_comb begin
    mem_we   = 1'b0;
    mem_wd   = 1'b0;
    mem_addr = voxel_addr(px, py, pz);
    if (cmd.clear) begin
      mem_we   = 1'b1;
      mem_addr = clr_cnt_r;
    end else if (cmd.accept) begin
      mem_wd   = in_solid;
      mem_addr = voxel_addr(int'(in_pos_x), int'(in_pos_y), int'(in_pos_z));
      mem_we   = (in_command == CMD_WRITE) &&
                 in_chunk(int'(in_pos_x), int'(in_pos_y), int'(in_pos_z));
    end
  end

  // Single-port occupancy store, read data registered.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    rd_r  <= mem[mem_addr];
    pin_r <= pin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear) begin
      clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_r <= in_pos_x;
      y_r <= in_pos_y;
      z_r <= in_pos_z;
    end
  end

  // Lowest pending face goes out first.
  always_comb begin
    sel_face = FACE_RIGHT;
    found    = 1'b0;
    for (int i = 0; i < NUM_FACES; i++) begin
      if (mask_r[i] && !found) begin
        sel_face = face_t'(i);
        found    = 1'b1;
      end
    end
    rest           = mask_r;
    rest[sel_face] = 1'b0;
  end

  assign cap_idx = face_t'(cmd.step - STEP_FACE_DATA);
  assign load    = cmd.emit && (mask_r != '0) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centre_r    <= 1'b0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        mask_r <= '0;
      end else if (cmd.probe && cmd.step == STEP_CENTRE_DATA) begin
        centre_r <= pin_r & rd_r;
      end else if (cmd.probe && (cmd.step inside {[STEP_FACE_DATA:STEP_LAST]})) begin
        // Neighbour must be inside and empty, and the voxel itself solid.
        mask_r[cap_idx] <= centre_r & pin_r & ~rd_r;
      end else if (load) begin
        mask_r <= rest;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the coordinates with the item, as the next input may arrive while it stalls.
  always_ff @(posedge clk) begin
    if (load) begin
      face_r   <= sel_face;
      face_x_r <= x_r;
      face_y_r <= y_r;
      face_z_r <= z_r;
      last_r   <= (rest == '0);
    end
  end

  assign status.clear_done = (clr_cnt_r == ADDR_W'(VOXELS - 1));
  assign status.is_query   = (in_command == CMD_QUERY);
  assign status.faces_left = (mask_r != '0);

  assign out_valid  = out_valid_r;
  assign out_face   = face_r;
  assign out_face_x = face_x_r;
  assign out_face_y = face_y_r;
  assign out_face_z = face_z_r;
  assign out_last   = last_r;

endmodule

### hdl/voxel_visible_face_finder_top.sv
// Voxel visible-face finder: one occupancy bit per voxel, face queries on request.
//
// in_ch takes items: command 0 writes the solid bit of voxel (pos_x, pos_y, pos_z),
// command 1 queries that voxel. A query of a solid voxel gives one out_ch item per
// face whose neighbour is inside the chunk and empty, in the order right, left,
// front, back, top, bottom; the final item of a query has last set. Faces on the
// chunk boundary and queries of empty voxels give nothing.
// A write is stored as it is accepted, and in_ch stays ready for the next item.
// A query is accepted, then the probe steps read the voxel and its six neighbours
// through the single port of the occupancy memory, then the faces are sent in
// turn and the controller returns to idle. The first face is presented from the
// output register once the probe steps are done. Items are handled one at a time.
// After reset the occupancy memory is cleared one voxel per cycle, while
// in_ch.ready stays low.
// A stalled out_ch holds its item in the output register and the face sequence
// waits; a finished last item does not keep the next in_ch item from being taken.
module voxel_visible_face_finder_top (
  input logic       clk,
  input logic       rst_n,
  vvff_in_if.sink   in_ch,
  vvff_out_if.source out_ch
);
  import vvff_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  vvff_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  vvff_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_command (in_ch.command),
    .in_pos_x   (in_ch.pos_x),
    .in_pos_y   (in_ch.pos_y),
    .in_pos_z   (in_ch.pos_z),
    .in_solid   (in_ch.solid),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_face   (out_ch.face),
    .out_face_x (out_ch.face_x),
    .out_face_y (out_ch.face_y),
    .out_face_z (out_ch.face_z),
    .out_last   (out_ch.last)
  );

  assign in_ch.ready = in_ready;

endmodule

### hdl/vvff_checker.sv
// Port-level checks of the voxel visible-face finder, bound to its top level.
module vvff_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_command,
  input logic              out_valid,
  input logic              out_ready,
  input vvff_pkg::face_t   out_face,
  input logic              out_last
);
  import vvff_pkg::*;
  `include "voxel_visible_face_finder_top_macros.svh"

  // Hold a stalled item.
  `VVFF_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "stalled item dropped")
  // The memory clear follows reset, so no item is taken right after it.
  `VVFF_ASSERT_RST(a_clear_after_reset, !rst_n |=> !in_ready, "item taken during clear")
  `VVFF_ASSERT(a_face_code, out_valid |-> out_face <= FACE_BOTTOM, "face code out of range")
  // Faces of one query follow each other without a gap.
  `VVFF_ASSERT(a_no_gap, out_valid && out_ready && !out_last |=> out_valid, "gap in faces")
  `VVFF_ASSERT(a_query_busy, in_valid && in_ready && in_command == CMD_QUERY |=> !in_ready,
    "item taken during query")

endmodule

bind voxel_visible_face_finder_top vvff_checker u_vvff_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_command (in_ch.command),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_face   (out_ch.face),
  .out_last   (out_ch.last)
);
